// ===== sv/mbc_pkg.sv =====
`timescale 1ns / 1ps

package mbc_pkg;

   // bus event codes
   localparam logic [2:0] OP_GAME_WRITE  = 3'd0;
   localparam logic [2:0] OP_PAGE_WRITE  = 3'd1;
   localparam logic [2:0] OP_VIDEO_WRITE = 3'd2;
   localparam logic [2:0] OP_PORT_LINE   = 3'd3;
   localparam logic [2:0] OP_PORT_READ   = 3'd4;

   localparam logic [2:0] GAME_MENU     = 3'd0;
   localparam logic [2:0] GAME_PAGED    = 3'd5;
   localparam logic [7:0] START_MASK    = 8'h30;
   localparam logic [3:0] PAGE_IO       = 4'd0;
   localparam logic [3:0] PAGE_HIGH_ROM = 4'd7;
   localparam logic [2:0] IO_BANK_IO    = 3'd0;
   localparam logic [2:0] IO_BANK_HIGH  = 3'd4;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] bus_data;
      logic [1:0] access_offset;
      logic       line_level;
   } req_type;

   typedef struct packed {
      logic [2:0] game;
      logic [3:0] main_bank;
      logic [2:0] code_bank;
      logic [2:0] io_page;
      logic       flip;
      logic       sound_cpu_reset;
      logic       main_cpu_reset;
      logic [4:0] left_port_index;
      logic [4:0] right_port_index;
      logic       unknown_page;
   } rsp_type;

   // input bank routed to the first player port
   function automatic logic [4:0] left_index(input logic [3:0] sel);
      logic [4:0] idx;
      case (sel)
         4'd0, 4'd1:   idx = 5'd0;
         4'd2, 4'd3:   idx = 5'd2;
         4'd4:         idx = 5'd5;
         4'd5:         idx = 5'd4;
         4'd6, 4'd7:   idx = 5'd7;
         4'd8, 4'd9:   idx = 5'd9;
         4'd10, 4'd11: idx = 5'd11;
         4'd12:        idx = 5'd14;
         4'd13:        idx = 5'd13;
         default:      idx = 5'd9;
      endcase
      return idx;
   endfunction

   // input bank routed to the second player port
   function automatic logic [4:0] right_index(input logic [3:0] sel);
      logic [4:0] idx;
      case (sel)
         4'd0, 4'd1:   idx = 5'd1;
         4'd2, 4'd3:   idx = 5'd3;
         4'd4, 4'd5:   idx = 5'd6;
         4'd6, 4'd7:   idx = 5'd8;
         4'd8, 4'd9:   idx = 5'd10;
         4'd10, 4'd11: idx = 5'd12;
         4'd12:        idx = 5'd16;
         4'd13:        idx = 5'd15;
         default:      idx = 5'd10;
      endcase
      return idx;
   endfunction

endpackage

// ===== sv/mbc_req_if.sv =====
`timescale 1ns / 1ps

interface mbc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [7:0] bus_data;
   logic [1:0] access_offset;
   logic       line_level;

   modport source (output valid, output opcode, output bus_data, output access_offset,
                   output line_level, input ready);
   modport sink (input valid, input opcode, input bus_data, input access_offset,
                 input line_level, output ready);
endinterface

// ===== sv/mbc_rsp_if.sv =====
`timescale 1ns / 1ps

interface mbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] game;
   logic [3:0] main_bank;
   logic [2:0] code_bank;
   logic [2:0] io_page;
   logic       flip;
   logic       sound_cpu_reset;
   logic       main_cpu_reset;
   logic [4:0] left_port_index;
   logic [4:0] right_port_index;
   logic       unknown_page;

   modport source (output valid, output game, output main_bank, output code_bank,
                   output io_page, output flip, output sound_cpu_reset,
                   output main_cpu_reset, output left_port_index,
                   output right_port_index, output unknown_page, input ready);
   modport sink (input valid, input game, input main_bank, input code_bank,
                 input io_page, input flip, input sound_cpu_reset,
                 input main_cpu_reset, input left_port_index,
                 input right_port_index, input unknown_page, output ready);
endinterface

// ===== sv/mbc_in_stage.sv =====
`timescale 1ns / 1ps

module mbc_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mbc_pkg::req_type in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output mbc_pkg::req_type out_item
);

   logic             valid_ff;
   logic             valid_in;
   mbc_pkg::req_type item_ff;

   // take a new beat whenever the register is empty or drains this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // hold the payload while stalled
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== sv/mbc_core.sv =====
`timescale 1ns / 1ps

module mbc_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  mbc_pkg::req_type in_item,
   output logic             out_valid,
   input  logic             out_ready,
   output mbc_pkg::rsp_type out_item
);

   logic [2:0] game_ff, game_in;
   logic [3:0] page_ff, page_in;
   logic [2:0] io_bank_ff, io_bank_in;
   logic       video_on_ff, video_on_in;
   logic [3:0] port_sel_ff, port_sel_in;
   logic       flip_ff, flip_in;
   logic       valid_ff;
   logic       advance;
   logic [2:0] new_game;
   logic [3:0] new_page;
   logic       game_change;
   logic       two_start;
   logic       snd_rst;
   logic       cpu_rst;
   logic       unk;
   mbc_pkg::rsp_type rsp_ff, rsp_in;

   assign in_ready = !valid_ff || out_ready;
   assign advance  = in_valid && in_ready;

   assign new_game = in_item.bus_data[2:0];
   assign new_page = in_item.bus_data[3:0];

   // a game change is allowed only to or from the menu
   assign game_change = (new_game != game_ff) &&
                        ((new_game == mbc_pkg::GAME_MENU) || (game_ff == mbc_pkg::GAME_MENU));
   assign two_start   = (game_ff != mbc_pkg::GAME_MENU) && (in_item.access_offset == 2'd0) &&
                        ((in_item.bus_data & mbc_pkg::START_MASK) == mbc_pkg::START_MASK);

   // work out the bank state after this beat
   always_comb begin
      game_in     = game_ff;
      page_in     = page_ff;
      io_bank_in  = io_bank_ff;
      video_on_in = video_on_ff;
      port_sel_in = port_sel_ff;
      flip_in     = flip_ff;
      snd_rst     = 1'b0;
      cpu_rst     = 1'b0;
      unk         = 1'b0;
      case (in_item.opcode)
         mbc_pkg::OP_GAME_WRITE: begin
            if (game_change) begin
               game_in = new_game;
               snd_rst = 1'b1;
               if (page_ff != mbc_pkg::PAGE_IO) begin
                  page_in    = mbc_pkg::PAGE_IO;
                  io_bank_in = mbc_pkg::IO_BANK_IO;
               end
            end
         end
         mbc_pkg::OP_PAGE_WRITE: begin
            if (new_page != page_ff) begin
               page_in = new_page;
               if (new_page == mbc_pkg::PAGE_IO) begin
                  io_bank_in = mbc_pkg::IO_BANK_IO;
               end else if (game_ff == mbc_pkg::GAME_PAGED) begin
                  if (new_page <= 4'd3) begin
                     io_bank_in = new_page[2:0];
                  end else if (new_page == mbc_pkg::PAGE_HIGH_ROM) begin
                     io_bank_in = mbc_pkg::IO_BANK_HIGH;
                  end else begin
                     unk = 1'b1;
                  end
               end
            end
         end
         mbc_pkg::OP_VIDEO_WRITE: begin
            video_on_in = in_item.bus_data[0];
            flip_in     = in_item.bus_data[1];
         end
         mbc_pkg::OP_PORT_LINE: begin
            port_sel_in = {game_ff, in_item.line_level};
         end
         mbc_pkg::OP_PORT_READ: begin
            // two starts outside the menu: back to the menu, reset both CPUs
            if (two_start) begin
               game_in = mbc_pkg::GAME_MENU;
               snd_rst = 1'b1;
               cpu_rst = 1'b1;
               if (page_ff != mbc_pkg::PAGE_IO) begin
                  page_in    = mbc_pkg::PAGE_IO;
                  io_bank_in = mbc_pkg::IO_BANK_IO;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // build the result beat from the new state
   always_comb begin
      rsp_in.game             = game_in;
      rsp_in.main_bank        = video_on_in ? ({1'b0, game_in} + 4'd1) : 4'd0;
      rsp_in.code_bank        = game_in;
      rsp_in.io_page          = io_bank_in;
      rsp_in.flip             = flip_in;
      rsp_in.sound_cpu_reset  = snd_rst;
      rsp_in.main_cpu_reset   = cpu_rst;
      rsp_in.left_port_index  = mbc_pkg::left_index(port_sel_in);
      rsp_in.right_port_index = mbc_pkg::right_index(port_sel_in);
      rsp_in.unknown_page     = unk;
   end

   // advance state and result together
   always_ff @(posedge clock) begin
      if (reset) begin
         game_ff     <= mbc_pkg::GAME_MENU;
         page_ff     <= mbc_pkg::PAGE_IO;
         io_bank_ff  <= mbc_pkg::IO_BANK_IO;
         video_on_ff <= 1'b0;
         port_sel_ff <= 4'd0;
         flip_ff     <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (advance) begin
            game_ff     <= game_in;
            page_ff     <= page_in;
            io_bank_ff  <= io_bank_in;
            video_on_ff <= video_on_in;
            port_sel_ff <= port_sel_in;
            flip_ff     <= flip_in;
         end
         if (in_ready) begin
            valid_ff <= in_valid;
         end
      end
   end

   // hold the result while the sink stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = rsp_ff;

endmodule

// ===== sv/multigame_bank_controller_top.sv =====
`timescale 1ns / 1ps

// Bank-switch controller of a multi-game board. Each request beat is one bus
// event (game-select write, page write, video-control write, port-select line
// change or player-port read) and gives exactly one response beat with the
// bank state after that event, plus the one-beat sound reset, main CPU reset
// and unknown-page flags. The block takes one beat per clock while the
// response side does not stall. Each request passes the input register and
// then the state update and result register, which builds its response from
// the new state. Back-pressure on the response side stalls the pipe, with
// the input register still taking one more beat.
module multigame_bank_controller_top (
   input logic      clock,
   input logic      reset,
   mbc_req_if.sink  req_bus,
   mbc_rsp_if.source rsp_bus
);

   mbc_pkg::req_type req_item;
   mbc_pkg::req_type stage_item;
   mbc_pkg::rsp_type rsp_item;
   logic             stage_valid;
   logic             stage_ready;

   assign req_item.opcode        = req_bus.opcode;
   assign req_item.bus_data      = req_bus.bus_data;
   assign req_item.access_offset = req_bus.access_offset;
   assign req_item.line_level    = req_bus.line_level;

   mbc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (req_bus.ready),
      .in_item   (req_item),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_item  (stage_item)
   );

   mbc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_ready  (stage_ready),
      .in_item   (stage_item),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_item  (rsp_item)
   );

   assign rsp_bus.game             = rsp_item.game;
   assign rsp_bus.main_bank        = rsp_item.main_bank;
   assign rsp_bus.code_bank        = rsp_item.code_bank;
   assign rsp_bus.io_page          = rsp_item.io_page;
   assign rsp_bus.flip             = rsp_item.flip;
   assign rsp_bus.sound_cpu_reset  = rsp_item.sound_cpu_reset;
   assign rsp_bus.main_cpu_reset   = rsp_item.main_cpu_reset;
   assign rsp_bus.left_port_index  = rsp_item.left_port_index;
   assign rsp_bus.right_port_index = rsp_item.right_port_index;
   assign rsp_bus.unknown_page     = rsp_item.unknown_page;

endmodule
